// ===== rtl/vtwl_pkg.sv =====
// vtwl_pkg: shared types, constants and helper functions of the vocabulary tree word lookup
`timescale 1ns / 1ps

package vtwl_pkg;

	localparam int MAX_LEVELS       = 3;
	localparam int MAX_BRANCH       = 8;
	localparam int DESC_DIM         = 32;
	localparam int CENTER_FRAC_BITS = 8;

	localparam int NODE_TOTAL   = MAX_BRANCH + MAX_BRANCH * MAX_BRANCH
		+ MAX_BRANCH * MAX_BRANCH * MAX_BRANCH;
	localparam int CENTER_DEPTH = NODE_TOTAL * DESC_DIM;

	localparam int LVL_W    = 2;
	localparam int CHILD_W  = 4;
	localparam int NODE_W   = 9;
	localparam int ELEM_W   = 5;
	localparam int CENTER_W = 16;
	localparam int QUERY_W  = 8;
	localparam int CFG_W    = 4;
	localparam int IDX_W    = NODE_W + CHILD_W;
	localparam int SLOT_W   = $clog2(NODE_TOTAL);
	localparam int CADDR_W  = $clog2(CENTER_DEPTH);
	localparam int SQ_W     = 2 * CENTER_W;
	localparam int ACC_W    = SQ_W + $clog2(DESC_DIM) + 1;

	typedef enum logic [1:0] {
		ACT_CENTER  = 2'd0,
		ACT_PRESENT = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_NONE    = 2'd3
	} vtwl_action_t;

	typedef enum logic [1:0] {
		CFG_LEVELS = 2'd0,
		CFG_BRANCH = 2'd1,
		CFG_READY  = 2'd2,
		CFG_SPARE  = 2'd3
	} vtwl_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LSTART,
		ST_PRES,
		ST_PCHK,
		ST_ELEM,
		ST_DRAIN,
		ST_CMP,
		ST_NEXT,
		ST_LEND,
		ST_DONE
	} vtwl_state_t;

	typedef struct packed {
		logic                take;
		logic                node_clr;
		logic                clr_en;
		logic [SLOT_W-1:0]   clr_addr;
		logic                lvl_start;
		logic                pres_rd;
		logic                acc_clr;
		logic                elem_issue;
		logic [ELEM_W-1:0]   elem;
		logic                cmp;
		logic                lvl_end;
		logic [LVL_W-1:0]    level;
		logic [CHILD_W-1:0]  child;
		logic [CHILD_W-1:0]  branch;
		logic                out_load;
		logic                out_nr;
	} vtwl_cmd_t;

	typedef struct packed {
		logic child_ok;
		logic pipe_busy;
		logic out_full;
	} vtwl_status_t;

	function automatic logic [IDX_W-1:0] level_cap(input logic [LVL_W-1:0] lvl);
		logic [IDX_W-1:0] c;
		c = IDX_W'(1);
		for (int i = 1; i <= MAX_LEVELS; i++) begin
			if (i <= int'(lvl)) begin
				c = IDX_W'(c * IDX_W'(MAX_BRANCH));
			end
		end
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		b = '0;
		c = IDX_W'(1);
		for (int i = 1; i <= MAX_LEVELS; i++) begin
			c = IDX_W'(c * IDX_W'(MAX_BRANCH));
			if (i < int'(lvl)) begin
				b = IDX_W'(b + c);
			end
		end
		return b;
	endfunction

	function automatic logic slot_ok(input logic [LVL_W-1:0] lvl, input logic [IDX_W-1:0] idx);
		return (lvl != '0) && (int'(lvl) <= MAX_LEVELS) && (idx < level_cap(lvl));
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [LVL_W-1:0] lvl,
		input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] s;
		s = IDX_W'(level_base(lvl) + idx);
		return s[SLOT_W-1:0];
	endfunction

endpackage

// ===== rtl/vtwl_dpath.sv =====
// vtwl_dpath: center, present and query stores, distance pipeline, best-child tracking, result register
`timescale 1ns / 1ps

module vtwl_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vtwl_pkg::vtwl_cmd_t                 cmd,
	output vtwl_pkg::vtwl_status_t              status,
	input  logic [1:0]                          action,
	input  logic [vtwl_pkg::LVL_W-1:0]          tree_level,
	input  logic [vtwl_pkg::NODE_W-1:0]         node_index,
	input  logic [vtwl_pkg::ELEM_W-1:0]         element_index,
	input  logic [vtwl_pkg::CENTER_W-1:0]       center_value,
	input  logic                                present,
	input  logic [vtwl_pkg::QUERY_W-1:0]        query_value,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [vtwl_pkg::NODE_W-1:0]         word_index,
	output logic                                not_ready
);

	logic [vtwl_pkg::CENTER_W-1:0] center_mem [vtwl_pkg::CENTER_DEPTH];
	logic                          present_mem [vtwl_pkg::NODE_TOTAL];
	logic [vtwl_pkg::QUERY_W-1:0]  query_mem [vtwl_pkg::DESC_DIM];

	logic [vtwl_pkg::IDX_W-1:0]    load_idx;
	logic                          load_ok;
	logic [vtwl_pkg::SLOT_W-1:0]   load_slot;
	logic [vtwl_pkg::IDX_W-1:0]    walk_idx;
	logic [vtwl_pkg::IDX_W-1:0]    next_idx;
	logic                          walk_ok;
	logic [vtwl_pkg::SLOT_W-1:0]   walk_slot;
	logic                          elem_ok;
	logic                          wr_center;
	logic                          wr_present;
	logic                          wr_query;
	logic                          pmem_we;
	logic [vtwl_pkg::SLOT_W-1:0]   pmem_waddr;
	logic                          pmem_wdata;
	logic [vtwl_pkg::CADDR_W-1:0]  cmem_waddr;
	logic [vtwl_pkg::CADDR_W-1:0]  cmem_raddr;

	logic [vtwl_pkg::SLOT_W-1:0]   slot_q;
	logic                          slot_ok_q;
	logic                          pres_q;
	logic [vtwl_pkg::CENTER_W-1:0] center_s1;
	logic [vtwl_pkg::QUERY_W-1:0]  query_s1;
	logic                          v_s1;
	logic [vtwl_pkg::CENTER_W-1:0] absd_s2;
	logic                          v_s2;
	logic [vtwl_pkg::SQ_W-1:0]     sq_s3;
	logic                          v_s3;
	logic [vtwl_pkg::ACC_W-1:0]    acc_q;
	logic [vtwl_pkg::ACC_W-1:0]    best_dist_q;
	logic [vtwl_pkg::CHILD_W-1:0]  best_q;
	logic                          found_q;
	logic [vtwl_pkg::NODE_W-1:0]   node_q;
	logic                          out_valid_q;
	logic [vtwl_pkg::NODE_W-1:0]   word_q;
	logic                          nr_q;
	logic [vtwl_pkg::CENTER_W-1:0] q_scaled;

	// address decode for loads and for the walk
	always_comb begin
		load_idx   = vtwl_pkg::IDX_W'(node_index);
		load_ok    = vtwl_pkg::slot_ok(tree_level, load_idx);
		load_slot  = vtwl_pkg::slot_of(tree_level, load_idx);
		walk_idx   = vtwl_pkg::IDX_W'(vtwl_pkg::IDX_W'(node_q) * vtwl_pkg::IDX_W'(cmd.branch)
			+ vtwl_pkg::IDX_W'(cmd.child));
		next_idx   = vtwl_pkg::IDX_W'(vtwl_pkg::IDX_W'(node_q) * vtwl_pkg::IDX_W'(cmd.branch)
			+ vtwl_pkg::IDX_W'(best_q));
		walk_ok    = vtwl_pkg::slot_ok(cmd.level, walk_idx);
		walk_slot  = vtwl_pkg::slot_of(cmd.level, walk_idx);
		elem_ok    = ({1'b0, element_index} < (vtwl_pkg::ELEM_W + 1)'(vtwl_pkg::DESC_DIM));
		wr_center  = cmd.take && (action == vtwl_pkg::ACT_CENTER) && load_ok && elem_ok;
		wr_present = cmd.take && (action == vtwl_pkg::ACT_PRESENT) && load_ok;
		wr_query   = cmd.take && (action == vtwl_pkg::ACT_QUERY) && elem_ok;
		pmem_we    = cmd.clr_en || wr_present;
		pmem_waddr = cmd.clr_en ? cmd.clr_addr : load_slot;
		pmem_wdata = cmd.clr_en ? 1'b0 : present;
		cmem_waddr = vtwl_pkg::CADDR_W'(vtwl_pkg::CADDR_W'(load_slot) * vtwl_pkg::DESC_DIM
			+ vtwl_pkg::CADDR_W'(element_index));
		cmem_raddr = vtwl_pkg::CADDR_W'(vtwl_pkg::CADDR_W'(slot_q) * vtwl_pkg::DESC_DIM
			+ vtwl_pkg::CADDR_W'(cmd.elem));
	end

	always_ff @(posedge clk) begin
		if (wr_center) begin
			center_mem[cmem_waddr] <= center_value;
		end
		center_s1 <= center_mem[cmem_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_query) begin
			query_mem[element_index] <= query_value;
		end
		query_s1 <= query_mem[cmd.elem];
	end

	always_ff @(posedge clk) begin
		if (pmem_we) begin
			present_mem[pmem_waddr] <= pmem_wdata;
		end
		pres_q <= present_mem[walk_slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.pres_rd) begin
			slot_q <= walk_slot;
		end
	end

	assign q_scaled = vtwl_pkg::CENTER_W'({query_s1, {vtwl_pkg::CENTER_FRAC_BITS{1'b0}}});

	// distance pipeline, payload only
	always_ff @(posedge clk) begin
		absd_s2 <= (q_scaled >= center_s1) ? (q_scaled - center_s1) : (center_s1 - q_scaled);
		sq_s3   <= vtwl_pkg::SQ_W'(absd_s2 * absd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			slot_ok_q   <= 1'b0;
			acc_q       <= '0;
			best_dist_q <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			node_q      <= '0;
			out_valid_q <= 1'b0;
			word_q      <= '0;
			nr_q        <= 1'b0;
		end else begin
			v_s1 <= cmd.elem_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.pres_rd) begin
				slot_ok_q <= walk_ok;
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (v_s3) begin
				acc_q <= vtwl_pkg::ACC_W'(acc_q + vtwl_pkg::ACC_W'(sq_s3));
			end
			if (cmd.lvl_start) begin
				found_q <= 1'b0;
				best_q  <= '0;
			end else if (cmd.cmp && (!found_q || (acc_q < best_dist_q))) begin
				found_q     <= 1'b1;
				best_dist_q <= acc_q;
				best_q      <= cmd.child;
			end
			if (cmd.node_clr) begin
				node_q <= '0;
			end else if (cmd.lvl_end) begin
				node_q <= next_idx[vtwl_pkg::NODE_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				word_q      <= cmd.out_nr ? '0 : node_q;
				nr_q        <= cmd.out_nr;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.child_ok  = pres_q && slot_ok_q;
	assign status.pipe_busy = v_s1 || v_s2 || v_s3;
	assign status.out_full  = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign word_index = word_q;
	assign not_ready  = nr_q;

endmodule

// ===== rtl/vtwl_ctrl.sv =====
// vtwl_ctrl: configuration registers and the sequencer of the clearing pass and the tree walk
`timescale 1ns / 1ps

module vtwl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [vtwl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic                          last_element,
	input  vtwl_pkg::vtwl_status_t        status,
	output vtwl_pkg::vtwl_cmd_t           cmd
);

	vtwl_pkg::vtwl_state_t         state_q;
	vtwl_pkg::vtwl_state_t         state_d;
	logic [vtwl_pkg::LVL_W-1:0]    levels_q;
	logic [vtwl_pkg::CHILD_W-1:0]  branch_q;
	logic                          ready_q;
	logic [vtwl_pkg::LVL_W-1:0]    levels_eff;
	logic [vtwl_pkg::CHILD_W-1:0]  branch_eff;
	logic [vtwl_pkg::LVL_W-1:0]    level_q;
	logic [vtwl_pkg::CHILD_W-1:0]  child_q;
	logic [vtwl_pkg::ELEM_W-1:0]   elem_q;
	logic [vtwl_pkg::SLOT_W-1:0]   clr_q;
	logic                          nr_q;
	logic                          start;
	logic                          last_child;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= vtwl_pkg::LVL_W'(3);
			branch_q <= vtwl_pkg::CHILD_W'(8);
			ready_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (vtwl_pkg::vtwl_cfg_idx_t'(cfg_index))
				vtwl_pkg::CFG_LEVELS: levels_q <= cfg_data[vtwl_pkg::LVL_W-1:0];
				vtwl_pkg::CFG_BRANCH: branch_q <= cfg_data[vtwl_pkg::CHILD_W-1:0];
				vtwl_pkg::CFG_READY:  ready_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		levels_eff = (int'(levels_q) > vtwl_pkg::MAX_LEVELS) ?
			vtwl_pkg::LVL_W'(vtwl_pkg::MAX_LEVELS) : levels_q;
		if (branch_q == '0) begin
			branch_eff = vtwl_pkg::CHILD_W'(1);
		end else if (int'(branch_q) > vtwl_pkg::MAX_BRANCH) begin
			branch_eff = vtwl_pkg::CHILD_W'(vtwl_pkg::MAX_BRANCH);
		end else begin
			branch_eff = branch_q;
		end
		start      = in_valid && (state_q == vtwl_pkg::ST_IDLE)
			&& (action == vtwl_pkg::ACT_QUERY) && last_element;
		last_child = (child_q == vtwl_pkg::CHILD_W'(branch_eff - 1'b1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vtwl_pkg::ST_CLEAR: begin
				if (clr_q == vtwl_pkg::SLOT_W'(vtwl_pkg::NODE_TOTAL - 1)) begin
					state_d = vtwl_pkg::ST_IDLE;
				end
			end
			vtwl_pkg::ST_IDLE: begin
				if (start) begin
					if (!ready_q || (levels_eff == '0)) begin
						state_d = vtwl_pkg::ST_DONE;
					end else begin
						state_d = vtwl_pkg::ST_LSTART;
					end
				end
			end
			vtwl_pkg::ST_LSTART: state_d = vtwl_pkg::ST_PRES;
			vtwl_pkg::ST_PRES:   state_d = vtwl_pkg::ST_PCHK;
			vtwl_pkg::ST_PCHK: begin
				state_d = status.child_ok ? vtwl_pkg::ST_ELEM : vtwl_pkg::ST_NEXT;
			end
			vtwl_pkg::ST_ELEM: begin
				if (elem_q == vtwl_pkg::ELEM_W'(vtwl_pkg::DESC_DIM - 1)) begin
					state_d = vtwl_pkg::ST_DRAIN;
				end
			end
			vtwl_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = vtwl_pkg::ST_CMP;
				end
			end
			vtwl_pkg::ST_CMP:  state_d = vtwl_pkg::ST_NEXT;
			vtwl_pkg::ST_NEXT: state_d = last_child ? vtwl_pkg::ST_LEND : vtwl_pkg::ST_PRES;
			vtwl_pkg::ST_LEND: begin
				state_d = (level_q == levels_eff) ? vtwl_pkg::ST_DONE : vtwl_pkg::ST_LSTART;
			end
			vtwl_pkg::ST_DONE: begin
				if (!status.out_full) begin
					state_d = vtwl_pkg::ST_IDLE;
				end
			end
			default: state_d = vtwl_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == vtwl_pkg::ST_IDLE);
		cmd            = '0;
		cmd.take       = in_valid && in_ready;
		cmd.node_clr   = start;
		cmd.clr_en     = (state_q == vtwl_pkg::ST_CLEAR);
		cmd.clr_addr   = clr_q;
		cmd.lvl_start  = (state_q == vtwl_pkg::ST_LSTART);
		cmd.pres_rd    = (state_q == vtwl_pkg::ST_PRES);
		cmd.acc_clr    = (state_q == vtwl_pkg::ST_PCHK);
		cmd.elem_issue = (state_q == vtwl_pkg::ST_ELEM);
		cmd.elem       = elem_q;
		cmd.cmp        = (state_q == vtwl_pkg::ST_CMP);
		cmd.lvl_end    = (state_q == vtwl_pkg::ST_LEND);
		cmd.level      = level_q;
		cmd.child      = child_q;
		cmd.branch     = branch_eff;
		cmd.out_load   = (state_q == vtwl_pkg::ST_DONE) && !status.out_full;
		cmd.out_nr     = nr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtwl_pkg::ST_CLEAR;
			clr_q   <= '0;
			level_q <= '0;
			child_q <= '0;
			elem_q  <= '0;
			nr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				vtwl_pkg::ST_CLEAR: clr_q <= vtwl_pkg::SLOT_W'(clr_q + 1'b1);
				vtwl_pkg::ST_IDLE: begin
					if (start) begin
						level_q <= vtwl_pkg::LVL_W'(1);
						nr_q    <= !ready_q;
					end
				end
				vtwl_pkg::ST_LSTART: child_q <= '0;
				vtwl_pkg::ST_PCHK:   elem_q  <= '0;
				vtwl_pkg::ST_ELEM:   elem_q  <= vtwl_pkg::ELEM_W'(elem_q + 1'b1);
				vtwl_pkg::ST_NEXT: begin
					if (!last_child) begin
						child_q <= vtwl_pkg::CHILD_W'(child_q + 1'b1);
					end
				end
				vtwl_pkg::ST_LEND: level_q <= vtwl_pkg::LVL_W'(level_q + 1'b1);
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/vocab_tree_word_lookup.sv =====
// vocab_tree_word_lookup: top level, sequencer and datapath of the vocabulary tree lookup
`timescale 1ns / 1ps

// After reset the block sweeps the 584 node present flags to zero, one per cycle, and takes
// no request until the sweep ends; configuration writes are taken throughout. A load request
// (center element or present flag) and a query byte without the last mark leave it idle.
// A query byte with the last mark starts the tree walk (or, when the tree is not ready or has
// no levels, only the result), and the next request is taken after it finishes. Each level
// has a start and an end step; each child has a present check, and each present child also
// has the distance unit read one center element per cycle from the center store (32 reads,
// then a pipeline drain and a compare). The result sits in an output register, so the block
// returns to idle as soon as that register is free.
module vocab_tree_word_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [vtwl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [vtwl_pkg::LVL_W-1:0]    tree_level,
	input  logic [vtwl_pkg::NODE_W-1:0]   node_index,
	input  logic [vtwl_pkg::ELEM_W-1:0]   element_index,
	input  logic [vtwl_pkg::CENTER_W-1:0] center_value,
	input  logic                          present,
	input  logic [vtwl_pkg::QUERY_W-1:0]  query_value,
	input  logic                          last_element,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vtwl_pkg::NODE_W-1:0]   word_index,
	output logic                          not_ready
);

	vtwl_pkg::vtwl_cmd_t    cmd;
	vtwl_pkg::vtwl_status_t status;

	vtwl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.last_element (last_element),
		.status       (status),
		.cmd          (cmd)
	);

	vtwl_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.action        (action),
		.tree_level    (tree_level),
		.node_index    (node_index),
		.element_index (element_index),
		.center_value  (center_value),
		.present       (present),
		.query_value   (query_value),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.word_index    (word_index),
		.not_ready     (not_ready)
	);

	// no request taken while the walk streams center elements
	a_no_take_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.elem_issue |-> !in_ready)
		else $error("request taken during tree walk");

	// a new result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result register overwritten");

	// store port users never collide
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.clr_en, cmd.pres_rd, cmd.elem_issue}))
		else $error("store port conflict");

	// compare only once the distance pipeline has drained
	a_cmp_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp |-> !status.pipe_busy)
		else $error("compare with distance in flight");

endmodule

// ===== dv/vocab_tree_word_lookup_test.sv =====
// vocab_tree_word_lookup_test: self-checking testbench with a tree walk predictor and random traffic
`timescale 1ns / 1ps

module vocab_tree_word_lookup_test;

	localparam int NODES = 584;

	typedef struct packed {
		logic [1:0]                    act;
		logic [vtwl_pkg::LVL_W-1:0]    lvl;
		logic [vtwl_pkg::NODE_W-1:0]   nidx;
		logic [vtwl_pkg::ELEM_W-1:0]   elem;
		logic [vtwl_pkg::CENTER_W-1:0] cval;
		logic                          pres;
		logic [vtwl_pkg::QUERY_W-1:0]  qval;
		logic                          last;
	} request_t;

	typedef struct packed {
		logic [vtwl_pkg::NODE_W-1:0] word;
		logic                        nr;
	} word_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [vtwl_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [vtwl_pkg::LVL_W-1:0] tree_level;
	logic [vtwl_pkg::NODE_W-1:0] node_index;
	logic [vtwl_pkg::ELEM_W-1:0] element_index;
	logic [vtwl_pkg::CENTER_W-1:0] center_value;
	logic present;
	logic [vtwl_pkg::QUERY_W-1:0] query_value;
	logic last_element;
	logic out_valid;
	logic out_ready;
	logic [vtwl_pkg::NODE_W-1:0] word_index;
	logic not_ready;

	vocab_tree_word_lookup u_dut (.*);

	// predictor state
	logic [vtwl_pkg::CENTER_W-1:0] centers [NODES*vtwl_pkg::DESC_DIM];
	logic                          node_on [NODES];
	logic                          node_loaded [NODES];
	logic [vtwl_pkg::QUERY_W-1:0]  qbuf [vtwl_pkg::DESC_DIM];
	logic [1:0]          levels_reg;
	logic [3:0]          branch_reg;
	logic                ready_reg;

	word_t expected_words [$];
	int errors;
	int requests_sent;
	bit tx_quiet;
	bit rx_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("** vocab_tree_word_lookup: FAILED **");
		$finish;
	end

	function automatic bit slot_lookup(input int lvl, input longint idx, output int slot);
		longint cap;
		int base;
		cap = 1;
		for (int i = 0; i < lvl; i++) cap = cap * vtwl_pkg::MAX_BRANCH;
		base = (lvl >= 2 ? 8 : 0) + (lvl >= 3 ? 64 : 0);
		slot = 0;
		if (lvl < 1 || lvl > vtwl_pkg::MAX_LEVELS || idx >= cap)
			return 1'b0;
		slot = base + int'(idx);
		return 1'b1;
	endfunction

	function automatic longint sq_dist(input int slot);
		longint sum;
		longint d;
		sum = 0;
		for (int i = 0; i < vtwl_pkg::DESC_DIM; i++) begin
			d = longint'({qbuf[i], 8'h00}) - longint'(centers[slot*vtwl_pkg::DESC_DIM+i]);
			sum += d * d;
		end
		return sum;
	endfunction

	function automatic logic [vtwl_pkg::NODE_W-1:0] walk_word();
		int lv;
		int br;
		longint node;
		bit found;
		longint best_d;
		longint d;
		int best;
		int slot;
		lv = levels_reg > vtwl_pkg::MAX_LEVELS ? vtwl_pkg::MAX_LEVELS : levels_reg;
		br = branch_reg == 0 ? 1 :
			(branch_reg > vtwl_pkg::MAX_BRANCH ? vtwl_pkg::MAX_BRANCH : branch_reg);
		node = 0;
		for (int l = 1; l <= lv; l++) begin
			found = 0;
			best_d = 0;
			best = 0;
			for (int c = 0; c < br; c++) begin
				if (slot_lookup(l, node * br + c, slot) && node_on[slot]) begin
					d = sq_dist(slot);
					if (!found || d < best_d) begin
						found = 1;
						best_d = d;
						best = c;
					end
				end
			end
			node = node * br + best;
		end
		return node[vtwl_pkg::NODE_W-1:0];
	endfunction

	function automatic void apply_request(input request_t r);
		int slot;
		word_t w;
		case (r.act)
			vtwl_pkg::ACT_CENTER: if (slot_lookup(r.lvl, r.nidx, slot))
				centers[slot*vtwl_pkg::DESC_DIM+r.elem] = r.cval;
			vtwl_pkg::ACT_PRESENT: if (slot_lookup(r.lvl, r.nidx, slot))
				node_on[slot] = r.pres;
			vtwl_pkg::ACT_QUERY: begin
				qbuf[r.elem] = r.qval;
				if (r.last) begin
					w.nr = !ready_reg;
					w.word = ready_reg ? walk_word() : '0;
					expected_words = {expected_words, w};
				end
			end
			default: ;
		endcase
	endfunction

	function automatic request_t rand_request();
		request_t r;
		r = request_t'({$urandom, $urandom});
		return r;
	endfunction

	task automatic send_request(input request_t r);
		int gap;
		bit ok;
		gap = tx_quiet ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		{action, tree_level, node_index, element_index, center_value, present, query_value,
			last_element} <= r;
		do begin
			#1;
			ok = in_ready;
			@(posedge clk);
			if (!ok) @(negedge clk);
		end while (!ok);
		apply_request(r);
		requests_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [3:0] lv, input logic [3:0] br, input logic [3:0] rdy);
		logic [3:0] vals [4];
		vals = '{lv, br, rdy, 4'($urandom)};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		levels_reg = lv[1:0];
		branch_reg = br;
		ready_reg = rdy[0];
	endtask

	task automatic send_query(input int elem, input logic [7:0] val, input bit last);
		request_t r;
		r = rand_request();
		r.act = vtwl_pkg::ACT_QUERY;
		r.elem = vtwl_pkg::ELEM_W'(elem);
		r.qval = val;
		r.last = last;
		send_request(r);
	endtask

	task automatic set_present(input int lvl, input int idx, input bit on);
		request_t r;
		r = rand_request();
		r.act = vtwl_pkg::ACT_PRESENT;
		r.lvl = vtwl_pkg::LVL_W'(lvl);
		r.nidx = vtwl_pkg::NODE_W'(idx);
		r.pres = on;
		send_request(r);
	endtask

	task automatic grow_node(input int lvl, input int idx);
		request_t r;
		int slot;
		if (!slot_lookup(lvl, idx, slot)) return;
		if (!node_loaded[slot]) begin
			for (int e = 0; e < vtwl_pkg::DESC_DIM; e++) begin
				r = rand_request();
				r.act = vtwl_pkg::ACT_CENTER;
				r.lvl = vtwl_pkg::LVL_W'(lvl);
				r.nidx = vtwl_pkg::NODE_W'(idx);
				r.elem = vtwl_pkg::ELEM_W'(e);
				case ($urandom_range(0, 5))
					0: r.cval = '0;
					1: r.cval = '1;
					default: ;
				endcase
				send_request(r);
			end
			node_loaded[slot] = 1'b1;
		end
		set_present(lvl, idx, 1'b1);
	endtask

	task automatic test_not_ready();
		request_t r;
		send_query(0, 8'h00, 1'b1);
		send_query(31, 8'hff, 1'b1);
		r = rand_request();
		r.act = vtwl_pkg::ACT_NONE;
		send_request(r);
		send_query(5, 8'h80, 1'b1);
	endtask

	task automatic test_bad_loads();
		request_t r;
		r = rand_request();
		r.act = vtwl_pkg::ACT_PRESENT;
		r.lvl = '0;
		r.pres = 1'b1;
		send_request(r);
		r.lvl = 2'd1;
		r.nidx = 9'd8;
		send_request(r);
		r.lvl = 2'd2;
		r.nidx = 9'd511;
		send_request(r);
		r.act = vtwl_pkg::ACT_CENTER;
		r.lvl = '0;
		send_request(r);
		r = rand_request();
		r.act = vtwl_pkg::ACT_NONE;
		r.last = 1'b1;
		send_request(r);
	endtask

	task automatic test_empty_tree();
		wait_idle();
		write_regs(4'd3, 4'd8, 4'd1);
		for (int e = 0; e < vtwl_pkg::DESC_DIM; e++)
			send_query(e, (e % 2) ? 8'hff : 8'h00, e == vtwl_pkg::DESC_DIM - 1);
		wait_idle();
		write_regs(4'd0, 4'd8, 4'd1);
		send_query(3, 8'h55, 1'b1);
		wait_idle();
		write_regs(4'd3, 4'd0, 4'd1);
		send_query(4, 8'haa, 1'b1);
	endtask

	task automatic test_random_walks();
		int lvl;
		int br;
		int cap;
		int parent;
		int slot;
		int k;
		int phase;
		request_t r;
		logic [3:0] presets [8][3];
		presets = '{'{3, 8, 1}, '{1, 2, 1}, '{2, 3, 1}, '{3, 15, 1},
			'{3, 2, 1}, '{2, 8, 0}, '{1, 8, 1}, '{3, 0, 1}};
		phase = 0;
		while (requests_sent < 1400) begin
			wait_idle();
			if (phase < 8)
				write_regs(presets[phase][0], presets[phase][1], presets[phase][2]);
			else
				write_regs(4'($urandom), 4'($urandom), 4'($urandom_range(0, 5) != 0));
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			phase++;
			br = branch_reg == 0 ? 1 :
				(branch_reg > vtwl_pkg::MAX_BRANCH ? vtwl_pkg::MAX_BRANCH : branch_reg);
			for (int n = 0; n < 150 && requests_sent < 1400; n++) begin
				k = $urandom_range(0, 99);
				if (k < 8) begin
					r = rand_request();
					if (r.act == vtwl_pkg::ACT_QUERY) r.act = vtwl_pkg::ACT_NONE;
					// an unloaded node never becomes present
					if (r.act == vtwl_pkg::ACT_PRESENT && slot_lookup(r.lvl, r.nidx, slot)
						&& !node_loaded[slot])
						r.pres = 1'b0;
					send_request(r);
				end else if (k < 20) begin
					slot = $urandom_range(0, NODES - 1);
					lvl = slot < 8 ? 1 : (slot < 72 ? 2 : 3);
					set_present(lvl, slot - (lvl == 1 ? 0 : (lvl == 2 ? 8 : 72)),
						node_loaded[slot] ? $urandom_range(0, 1) : 1'b0);
				end else if (k < 26) begin
					lvl = $urandom_range(1, 3);
					cap = 1;
					for (int i = 1; i < lvl; i++) cap *= br;
					parent = $urandom_range(0, (cap < 4 ? cap : 4) - 1);
					grow_node(lvl, parent * br + $urandom_range(0, br - 1));
				end else begin
					k = $urandom_range(0, 5);
					for (int i = 0; i < k; i++)
						send_query($urandom_range(0, 31), 8'($urandom), 1'b0);
					send_query($urandom_range(0, 31), 8'($urandom), 1'b1);
				end
			end
		end
	endtask

	// result side: stall, sample before the edge, compare after it
	initial begin
		bit took;
		word_t got;
		word_t want;
		int gap;
		out_ready = 1'b0;
		gap = 0;
		forever begin
			@(negedge clk);
			out_ready <= (gap == 0);
			if (gap > 0) gap--;
			#1;
			took = out_valid && out_ready;
			got = '{word_index, not_ready};
			@(posedge clk);
			if (took) begin
				gap = rx_quiet ? 0 : $urandom_range(0, 6);
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: got %0d/%0b", $time, got.word, got.nr);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.word !== want.word)
						$display("%0t: word_index expected %0d actual %0d", $time, want.word,
							got.word);
					if (got.nr !== want.nr)
						$display("%0t: not_ready expected %0b actual %0b", $time, want.nr,
							got.nr);
					if (got !== want) errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		requests_sent = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		{action, tree_level, node_index, element_index, center_value, present, query_value,
			last_element} = '0;
		levels_reg = 2'd3;
		branch_reg = 4'd8;
		ready_reg = 1'b0;
		for (int i = 0; i < NODES; i++) begin
			node_on[i] = 1'b0;
			node_loaded[i] = 1'b0;
		end
		for (int i = 0; i < NODES * vtwl_pkg::DESC_DIM; i++) centers[i] = '0;
		for (int i = 0; i < vtwl_pkg::DESC_DIM; i++) qbuf[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_not_ready();
		test_bad_loads();
		test_empty_tree();
		test_random_walks();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** vocab_tree_word_lookup: PASSED **");
		else
			$display("** vocab_tree_word_lookup: FAILED **");
		$finish;
	end

endmodule
